[rtl/rfb_pkg.sv]
package rfb_pkg;

  localparam int unsigned H_BITS_DEF = 8;
  localparam int unsigned V_BITS_DEF = 7;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_RECT  = 3'd1,
    OP_FILL  = 3'd2,
    OP_SWAP  = 3'd3,
    OP_READ  = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [31:0] color_in;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] read_pixel;
  } res_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic fill_setup;
    logic wr_en;
    logic step;
    logic rd_en;
    logic swap;
  } dp_ctrl_t;

  typedef struct packed {
    opcode_e op;
    logic    ok;
    logic    empty;
    logic    last;
  } dp_status_t;

endpackage

[rtl/rect_fill_framebuffer_rgb565.sv]
// double-buffered rgb565 drawing engine
// a command word is taken on cmd_i at a rising edge with start_i high and
// busy_o low; busy_o stays high until the command's result word is shown
// each command gives exactly one result word on res_o, marked by done_o for
// one cycle; the receiver cannot stall, so done_o never waits
// pixel, swap, read, rejected and empty commands go from decode straight to
// the result word; an accepted rectangle and fill-and-swap first walk their
// pixels; a new command is taken only once busy_o is low again, after the
// result word; the walk over the pixels of a rectangle or bank writes one
// pixel per cycle through the single write port of the frame store, which
// sets the fill time
// reads go through the registered read port of the same store
// reset returns the controller to idle and makes bank one the back bank;
// the frame store is not cleared and holds no defined value until drawn
module rect_fill_framebuffer_rgb565 #(
  parameter int unsigned H_BITS = rfb_pkg::H_BITS_DEF,
  parameter int unsigned V_BITS = rfb_pkg::V_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rfb_pkg::cmd_t  cmd_i,
  output logic           busy_o,
  output logic           done_o,
  output rfb_pkg::res_t  res_o
);
  import rfb_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  rfb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  rfb_datapath #(
    .H_BITS (H_BITS),
    .V_BITS (V_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .ctrl_i   (ctrl),
    .status_o (status),
    .res_o    (res_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside a command");

  a_start_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("command accepted but not held busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.accepted) |-> (res_o.read_pixel == '0))
    else $error("rejected command returned pixel data");

endmodule

[rtl/rfb_datapath.sv]
module rfb_datapath #(
  parameter int unsigned H_BITS = rfb_pkg::H_BITS_DEF,
  parameter int unsigned V_BITS = rfb_pkg::V_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rfb_pkg::cmd_t        cmd_i,
  input  rfb_pkg::dp_ctrl_t    ctrl_i,
  output rfb_pkg::dp_status_t  status_o,
  output rfb_pkg::res_t        res_o
);
  import rfb_pkg::*;

  localparam int unsigned AW    = H_BITS + V_BITS + 1;
  localparam int unsigned DEPTH = 2 ** AW;

  logic [15:0] mem [DEPTH];

  opcode_e           op_q;
  logic [15:0]       x_q, y_q, w_q, h_q;
  logic [15:0]       color_q;
  logic [H_BITS-1:0] cx_q, x0_q, xend_q;
  logic [V_BITS-1:0] cy_q, yend_q;
  logic              back_sel_q;
  logic              acc_q;
  logic              rd_flag_q;
  logic [15:0]       rdata_q;

  logic [H_BITS-1:0] cx_inc;
  logic [V_BITS-1:0] cy_inc;
  logic [16:0]       sum_x, sum_y;
  logic              pix_in, rect_in, ok;
  logic [AW-1:0]     wr_addr, rd_addr;

  assign cx_inc  = cx_q + H_BITS'(1);
  assign cy_inc  = cy_q + V_BITS'(1);
  assign sum_x   = {1'b0, x_q} + {1'b0, w_q};
  assign sum_y   = {1'b0, y_q} + {1'b0, h_q};
  assign pix_in  = (x_q[15:H_BITS] == '0) && (y_q[15:V_BITS] == '0);
  assign rect_in = (sum_x[16:H_BITS] == '0) && (sum_y[16:V_BITS] == '0);
  assign wr_addr = {~back_sel_q, cy_q, cx_q};
  assign rd_addr = {back_sel_q, y_q[V_BITS-1:0], x_q[H_BITS-1:0]};

  always_comb begin
    unique case (op_q) inside
      OP_PIXEL, OP_READ: ok = pix_in;
      OP_RECT:           ok = rect_in;
      OP_FILL, OP_SWAP:  ok = 1'b1;
      default:           ok = 1'b0;
    endcase
  end

  assign status_o.op    = op_q;
  assign status_o.ok    = ok;
  assign status_o.empty = (w_q == '0) || (h_q == '0);
  assign status_o.last  = (cx_inc == xend_q) && (cy_inc == yend_q);

  assign res_o.accepted   = acc_q;
  assign res_o.read_pixel = rd_flag_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q    <= opcode_e'(cmd_i.opcode);
      x_q     <= cmd_i.pos_x;
      y_q     <= cmd_i.pos_y;
      w_q     <= cmd_i.rect_width;
      h_q     <= cmd_i.rect_height;
      color_q <= {cmd_i.color_in[23:19], cmd_i.color_in[15:10], cmd_i.color_in[7:3]};
      cx_q    <= cmd_i.pos_x[H_BITS-1:0];
      x0_q    <= cmd_i.pos_x[H_BITS-1:0];
      cy_q    <= cmd_i.pos_y[V_BITS-1:0];
      xend_q  <= cmd_i.pos_x[H_BITS-1:0] + cmd_i.rect_width[H_BITS-1:0];
      yend_q  <= cmd_i.pos_y[V_BITS-1:0] + cmd_i.rect_height[V_BITS-1:0];
    end else if (ctrl_i.fill_setup) begin
      cx_q   <= '0;
      x0_q   <= '0;
      cy_q   <= '0;
      xend_q <= '0;
      yend_q <= '0;
    end else if (ctrl_i.step) begin
      if (cx_inc == xend_q) begin
        cx_q <= x0_q;
        cy_q <= cy_inc;
      end else begin
        cx_q <= cx_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_sel_q <= 1'b0;
      acc_q      <= 1'b0;
      rd_flag_q  <= 1'b0;
    end else begin
      if (ctrl_i.swap) begin
        back_sel_q <= ~back_sel_q;
      end
      if (ctrl_i.load) begin
        acc_q     <= 1'b0;
        rd_flag_q <= 1'b0;
      end else begin
        if (ctrl_i.decide) begin
          acc_q <= ok;
        end
        if (ctrl_i.rd_en) begin
          rd_flag_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr] <= color_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

[rtl/rfb_ctrl.sv]
module rfb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  rfb_pkg::dp_status_t  status_i,
  output rfb_pkg::dp_ctrl_t    ctrl_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import rfb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctrl_o.decide = 1'b1;
        state_d       = ST_DONE;
        unique case (status_i.op)
          OP_PIXEL: ctrl_o.wr_en = status_i.ok;
          OP_RECT: begin
            if (status_i.ok && !status_i.empty) begin
              state_d = ST_WALK;
            end
          end
          OP_FILL: begin
            ctrl_o.fill_setup = 1'b1;
            state_d           = ST_WALK;
          end
          OP_SWAP:  ctrl_o.swap  = 1'b1;
          OP_READ:  ctrl_o.rd_en = status_i.ok;
          default: ;
        endcase
      end
      ST_WALK: begin
        ctrl_o.wr_en = 1'b1;
        ctrl_o.step  = 1'b1;
        if (status_i.last) begin
          state_d = ST_DONE;
          if (status_i.op == OP_FILL) begin
            ctrl_o.swap = 1'b1;
          end
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

[tb/frame_checker.sv]
module frame_checker
  import rfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  cmd_t        cmd_i,
  input  logic        busy_i,
  input  logic        done_i,
  input  res_t        res_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HRES        = 1 << H_BITS_DEF;
  localparam int unsigned VRES        = 1 << V_BITS_DEF;
  localparam int unsigned BANK_PIXELS = HRES * VRES;

  logic [15:0] frame_mem [2][BANK_PIXELS];
  logic        front_bank = 1'b0;
  res_t        expected_results [$];
  res_t        want;
  int unsigned fail_cnt = 0;
  int unsigned pending_cnt = 0;
  int unsigned checked_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_cnt;
  assign checked_o  = checked_cnt;

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_cnt++;
  endtask

  function automatic int unsigned pixel_index(int unsigned x, int unsigned y);
    return (y << H_BITS_DEF) + x;
  endfunction

  // applies one command word to the shadow frame store and returns its result
  function automatic res_t draw_command(cmd_t c);
    res_t        r;
    logic [15:0] col;
    logic        back;
    int unsigned x_end;
    int unsigned y_end;
    int unsigned i;
    int unsigned j;
    r     = '0;
    col   = {c.color_in[23:19], c.color_in[15:10], c.color_in[7:3]};
    back  = ~front_bank;
    x_end = 32'(c.pos_x) + 32'(c.rect_width);
    y_end = 32'(c.pos_y) + 32'(c.rect_height);
    case (c.opcode)
      OP_PIXEL: begin
        if (c.pos_x < HRES && c.pos_y < VRES) begin
          frame_mem[back][pixel_index(32'(c.pos_x), 32'(c.pos_y))] = col;
          r.accepted = 1'b1;
        end
      end
      OP_RECT: begin
        if (x_end < HRES && y_end < VRES) begin
          for (j = 32'(c.pos_y); j < y_end; j++) begin
            for (i = 32'(c.pos_x); i < x_end; i++) begin
              frame_mem[back][pixel_index(i, j)] = col;
            end
          end
          r.accepted = 1'b1;
        end
      end
      OP_FILL: begin
        for (i = 0; i < BANK_PIXELS; i++) begin
          frame_mem[back][i] = col;
        end
        front_bank = back;
        r.accepted = 1'b1;
      end
      OP_SWAP: begin
        front_bank = back;
        r.accepted = 1'b1;
      end
      OP_READ: begin
        if (c.pos_x < HRES && c.pos_y < VRES) begin
          r.read_pixel = frame_mem[front_bank][pixel_index(32'(c.pos_x), 32'(c.pos_y))];
          r.accepted   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_bank = 1'b0;
      expected_results.delete();
      pending_cnt = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with no command pending", res_i));
        end else begin
          want = expected_results.pop_front();
          if (res_i.accepted !== want.accepted) begin
            report_mismatch($sformatf("result %0d: accepted %b, expected %b",
                                      checked_cnt, res_i.accepted, want.accepted));
          end
          if (res_i.read_pixel !== want.read_pixel) begin
            report_mismatch($sformatf("result %0d: read_pixel %h, expected %h",
                                      checked_cnt, res_i.read_pixel, want.read_pixel));
          end
          checked_cnt++;
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        expected_results.push_back(draw_command(cmd_i));
      end
      pending_cnt = expected_results.size();
    end
  end

endmodule

[tb/tb_top.sv]
module tb_top
  import rfb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HRES         = 1 << H_BITS_DEF;
  localparam int unsigned VRES         = 1 << V_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 75;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam logic [2:0]  OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0]  OP_UNDEF_LAST  = 3'd7;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  cmd_t        cmd_i   = '0;
  logic        busy_o;
  logic        done_o;
  res_t        res_o;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycle_cnt = 0;
  int unsigned sent_by_op [8] = '{default: 0};
  logic        burst_mode = 1'b0;

  always #10 clk_i = ~clk_i;

  rect_fill_framebuffer_rgb565 dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .cmd_i,
    .busy_o,
    .done_o,
    .res_o
  );

  frame_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .cmd_i,
    .busy_i     (busy_o),
    .done_i     (done_o),
    .res_i      (res_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  function automatic cmd_t make_word(logic [2:0] op, logic [15:0] x, logic [15:0] y,
                                     logic [15:0] w, logic [15:0] h, logic [31:0] col);
    cmd_t c;
    c.opcode      = op;
    c.pos_x       = x;
    c.pos_y       = y;
    c.rect_width  = w;
    c.rect_height = h;
    c.color_in    = col;
    return c;
  endfunction

  function automatic cmd_t random_word(logic [2:0] op);
    return make_word(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     $urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(cmd_t c);
    int unsigned gap;
    if ($urandom_range(0, 7) == 0) burst_mode = ~burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    sent_by_op[c.opcode]++;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("no finish after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("rect_fill_framebuffer_rgb565 test failed");
    $finish;
  end

  initial begin
    cmd_t        c;
    int unsigned k;
    int unsigned n_items;
    int unsigned pick;
    int unsigned kind;
    int unsigned fills_left;
    int unsigned big_left;
    logic [15:0] last_x;
    logic [15:0] last_y;
    fills_left = 2;
    big_left   = 3;
    last_x     = '0;
    last_y     = '0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: bank one is back after reset
    send_word(make_word(OP_PIXEL, 16'd0, 16'd0, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF));
    send_word(make_word(OP_PIXEL, 16'(HRES - 1), 16'(VRES - 1), 16'd0, 16'd0, 32'h0));
    send_word(make_word(OP_PIXEL, 16'(HRES), 16'd0, 16'd0, 16'd0, $urandom));
    send_word(make_word(OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom));
    send_word(make_word(OP_PIXEL, 16'd0, 16'(VRES), 16'd0, 16'd0, $urandom));
    send_word(make_word(OP_RECT, 16'd1, 16'd1, 16'd2, 16'd2, 32'hAB12_3456));
    send_word(make_word(OP_RECT, 16'(HRES - 6), 16'd0, 16'd6, 16'd1, $urandom));
    send_word(make_word(OP_RECT, 16'd0, 16'(VRES - 8), 16'd1, 16'd8, $urandom));
    send_word(make_word(OP_RECT, 16'd10, 16'd10, 16'd0, 16'd5, $urandom));
    send_word(make_word(OP_RECT, 16'h0010, 16'd0, 16'hFFF8, 16'd1, $urandom));
    send_word(random_word(OP_SWAP));
    send_word(make_word(OP_READ, 16'd0, 16'd0, 16'd0, 16'd0, $urandom));
    send_word(make_word(OP_READ, 16'(HRES - 1), 16'(VRES - 1), 16'd0, 16'd0, $urandom));
    send_word(make_word(OP_READ, 16'd2, 16'd2, 16'hFFFF, 16'hFFFF, $urandom));
    send_word(make_word(OP_READ, 16'(HRES), 16'd0, 16'd0, 16'd0, $urandom));
    send_word(make_word(OP_READ, 16'hFFFF, 16'd5, 16'd0, 16'd0, $urandom));
    for (k = 32'(OP_UNDEF_FIRST); k <= 32'(OP_UNDEF_LAST); k++) begin
      send_word(random_word(3'(k)));
    end
    wait_idle();
    send_word(make_word(OP_FILL, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 32'h5A5A_A5A5));
    send_word(make_word(OP_READ, 16'd100, 16'd50, 16'd0, 16'd0, $urandom));
    send_word(make_word(OP_FILL, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 32'h00C3_3C96));
    send_word(make_word(OP_RECT, 16'd0, 16'd0, 16'(HRES - 1), 16'(VRES - 1), 32'h7F80_FF01));
    send_word(random_word(OP_SWAP));
    send_word(make_word(OP_READ, 16'(HRES - 2), 16'(VRES - 2), 16'd0, 16'd0, $urandom));
    send_word(make_word(OP_READ, 16'(HRES - 1), 16'(VRES - 1), 16'd0, 16'd0, $urandom));

    // random: both banks are fully drawn from here on
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        c = random_word(OP_PIXEL);
        if ($urandom_range(0, 6) != 0) begin
          c.pos_x = 16'($urandom_range(0, HRES - 1));
          c.pos_y = 16'($urandom_range(0, VRES - 1));
        end
        last_x = c.pos_x;
        last_y = c.pos_y;
        send_word(c);
        n_items++;
      end else if (pick < 50) begin
        c    = random_word(OP_RECT);
        kind = $urandom_range(0, 19);
        if (kind < 17) begin
          if (kind == 0 && big_left != 0) begin
            big_left--;
            c.rect_width  = 16'($urandom_range(64, HRES - 1));
            c.rect_height = 16'($urandom_range(32, VRES - 1));
          end else begin
            c.rect_width  = 16'($urandom_range(0, 8));
            c.rect_height = 16'($urandom_range(0, 8));
          end
          c.pos_x = 16'($urandom_range(0, HRES - 1 - 32'(c.rect_width)));
          c.pos_y = 16'($urandom_range(0, VRES - 1 - 32'(c.rect_height)));
          if (kind == 16) c.pos_x = 16'(HRES - 32'(c.rect_width));
        end
        last_x = c.pos_x;
        last_y = c.pos_y;
        send_word(c);
        n_items++;
      end else if (pick < 58) begin
        send_word(random_word(OP_SWAP));
        n_items++;
      end else if (pick < 88) begin
        c    = random_word(OP_READ);
        kind = $urandom_range(0, 19);
        if (kind < 9) begin
          c.pos_x = last_x;
          c.pos_y = last_y;
        end else if (kind < 17) begin
          c.pos_x = 16'($urandom_range(0, HRES - 1));
          c.pos_y = 16'($urandom_range(0, VRES - 1));
        end
        send_word(c);
        n_items++;
      end else if (pick < 93) begin
        send_word(random_word(3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST))));
      end else if (pick < 95) begin
        if (fills_left != 0) begin
          fills_left--;
          send_word(random_word(OP_FILL));
        end else begin
          send_word(random_word(OP_SWAP));
        end
        n_items++;
      end else begin
        wait_idle();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("commands: %0d pixel, %0d rectangle, %0d fill-and-swap, %0d swap, %0d read",
             sent_by_op[OP_PIXEL], sent_by_op[OP_RECT], sent_by_op[OP_FILL],
             sent_by_op[OP_SWAP], sent_by_op[OP_READ]);
    $display("plus %0d undefined; %0d result words compared, %0d mismatches, %0d cycles",
             sent_by_op[5] + sent_by_op[6] + sent_by_op[7], checked, fail_cnt, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("rect_fill_framebuffer_rgb565 test passed");
    end else begin
      $display("rect_fill_framebuffer_rgb565 test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rfb_pkg.sv
rtl/rfb_datapath.sv
rtl/rfb_ctrl.sv
rtl/rect_fill_framebuffer_rgb565.sv
tb/frame_checker.sv
tb/tb_top.sv
